>>> hw/rtl/gyro_heading_proportional_turn_assert.svh
// assertion macros shared by the gyro heading turn block
`ifndef GYRO_HEADING_PROPORTIONAL_TURN_ASSERT_SVH
`define GYRO_HEADING_PROPORTIONAL_TURN_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define GHPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ghpt assertion failed");

`define GHPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ghpt assertion failed");

`else

`define GHPT_ASSERT_IMP(lbl, ante, cons)

`define GHPT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/ghpt_pkg.sv
`default_nettype none
package ghpt_pkg;

  localparam int MIN_INTERVAL_MS_DEF = 5;
  localparam int COUNT_BITS_DEF      = 12;

  // action codes
  localparam logic [1:0] ACT_CONTROL = 2'd0;
  localparam logic [1:0] ACT_CALIB   = 2'd1;
  localparam logic [1:0] ACT_FINISH  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_GOAL = 2'd0;
  localparam logic [1:0] REG_SPAN = 2'd1;
  localparam logic [1:0] REG_MAXP = 2'd2;
  localparam logic [1:0] REG_MINP = 2'd3;

  localparam int ACT_W  = 2;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 10;
  localparam int GOAL_W = 10;
  localparam int PWRC_W = 7;
  localparam int RATE_W = 16;
  localparam int MS_W   = 10;
  localparam int PWR_W  = 8;
  localparam int HEAD_W = 26;

  localparam int UNITS_PER_DEG  = 64 * 1000;
  localparam int FULL_TURN      = 360 * UNITS_PER_DEG;
  localparam int POWER_LIMIT    = 100;
  localparam int DEADBAND_DEG   = 1;
  localparam int ERR_OFFSET_DEG = 10;

  localparam int GOAL_RST = 90;
  localparam int SPAN_RST = 90;
  localparam int MAXP_RST = 95;
  localparam int MINP_RST = 15;

  // shared divider: dividend, divisor and quotient widths
  localparam int DIVD_W   = 36;
  localparam int DIVS_W   = 25;
  localparam int QW       = 18;
  localparam int DRIFT_QW = 16;

  typedef struct packed {
    logic load;
    logic calib;
    logic fin_start;
    logic fin_end;
    logic mul;
    logic sum;
    logic head;
    logic err;
    logic num;
    logic div_start;
    logic out_load;
    logic out_zero;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_room;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/ghpt_div.sv
`default_nettype none
module ghpt_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        short_q,
  input  wire logic [ghpt_pkg::DIVD_W-1:0] dividend,
  input  wire logic [ghpt_pkg::DIVS_W-1:0] divisor,
  output logic                             busy,
  output logic [ghpt_pkg::QW-1:0]          quot
);
  import ghpt_pkg::*;

  localparam int DSH_W = DIVS_W + QW - 1;
  localparam int CNT_W = $clog2(QW);

  logic [DIVD_W-1:0] rem;
  logic [DSH_W-1:0]  dsh;
  logic [CNT_W-1:0]  cnt;
  logic              fits;

  assign fits = DSH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      quot <= '0;
      if (short_q) begin
        dsh <= DSH_W'(divisor) << (DRIFT_QW - 1);
        cnt <= CNT_W'(DRIFT_QW - 1);
      end else begin
        dsh <= DSH_W'(divisor) << (QW - 1);
        cnt <= CNT_W'(QW - 1);
      end
    end else if (busy) begin
      if (fits) begin
        rem  <= rem - dsh[DIVD_W-1:0];
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        quot <= {quot[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ghpt_dp.sv
`default_nettype none
module ghpt_dp #(
  parameter int MIN_INTERVAL_MS = ghpt_pkg::MIN_INTERVAL_MS_DEF,
  parameter int COUNT_BITS      = ghpt_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ghpt_pkg::cmd_t                     cmd,
  output ghpt_pkg::status_t                       status,
  input  wire logic signed [ghpt_pkg::RATE_W-1:0] rate_sample,
  input  wire logic [ghpt_pkg::MS_W-1:0]          elapsed_ms,
  input  wire logic                               cfg_valid,
  input  wire logic [ghpt_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [ghpt_pkg::CFG_W-1:0]         cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ghpt_pkg::PWR_W-1:0]       left_power,
  output logic signed [ghpt_pkg::PWR_W-1:0]       right_power,
  output logic                                    turn_done,
  output logic signed [ghpt_pkg::HEAD_W-1:0]      heading_now
);
  import ghpt_pkg::*;

  localparam int PEND_W  = $clog2(MIN_INTERVAL_MS + 2 ** MS_W - 1);
  localparam int SUM_W   = RATE_W + COUNT_BITS;
  localparam int DELTA_W = RATE_W + 1;
  localparam int PROD_W  = DELTA_W + PEND_W + 1;
  localparam int HS_W    = PROD_W + 1;
  localparam int GU_W    = 28;

  localparam logic [PEND_W-1:0]      MIN_P   = PEND_W'(MIN_INTERVAL_MS);
  localparam logic signed [HS_W-1:0] FULL_H  = HS_W'(FULL_TURN);
  localparam logic signed [HS_W-1:0] NFULL_H = -FULL_H;
  localparam logic signed [GU_W-1:0] UNIT_G  = GU_W'(DEADBAND_DEG * UNITS_PER_DEG);
  localparam logic signed [GU_W-1:0] OFFS_G  = GU_W'(ERR_OFFSET_DEG * UNITS_PER_DEG);
  localparam logic signed [GU_W-1:0] UPD_G   = GU_W'(UNITS_PER_DEG);

  // configuration
  logic signed [GOAL_W-1:0] goal;
  logic signed [GOAL_W-1:0] span;
  logic [PWRC_W-1:0]        maxp;
  logic [PWRC_W-1:0]        minp;

  // block state
  logic signed [HEAD_W-1:0] heading;
  logic [PEND_W-1:0]        pending;
  logic signed [RATE_W-1:0] drift;
  logic signed [SUM_W-1:0]  csum;
  logic [COUNT_BITS-1:0]    ccount;

  // per item working registers
  logic signed [RATE_W-1:0] rate_r;
  logic [MS_W-1:0]          ms_r;
  logic signed [PROD_W-1:0] prod;
  logic                     upd;
  logic signed [HS_W-1:0]   hsum;
  logic [DIVS_W-1:0]        den;
  logic signed [GU_W-1:0]   gunits;
  logic signed [GU_W-1:0]   errm;
  logic [DIVD_W-1:0]        mind;
  logic signed [DIVD_W-1:0] num;
  logic                     below;
  logic                     above;
  logic                     qneg;

  logic signed [DELTA_W-1:0] delta;
  logic [PEND_W-1:0]         pend_sum;
  logic                      pend_due;
  logic signed [HS_W-1:0]    hwrap;
  logic signed [HS_W-1:0]    hsat;
  logic [GOAL_W:0]           span_mag;
  logic signed [GU_W-1:0]    hdiff;
  logic signed [DIVD_W-1:0]  pp;
  logic [DIVD_W-1:0]         num_mag;
  logic [SUM_W-1:0]          csum_mag;
  logic                      div_busy;
  logic [QW-1:0]             quot;
  logic [DIVD_W-1:0]         div_dividend;
  logic [DIVS_W-1:0]         div_divisor;
  logic [PWRC_W-1:0]         qsat;
  logic signed [PWR_W-1:0]   pwr;
  logic [DRIFT_QW-1:0]       dq;

  assign delta    = DELTA_W'(rate_r) - DELTA_W'(drift);
  assign pend_sum = pending + PEND_W'(ms_r);
  assign pend_due = pend_sum >= MIN_P;

  always_comb begin
    hwrap = hsum;
    if (hsum > FULL_H) begin
      hwrap = hsum - FULL_H;
    end else if (hsum < NFULL_H) begin
      hwrap = hsum + FULL_H;
    end
    hsat = hwrap;
    if (hwrap > FULL_H) begin
      hsat = FULL_H;
    end else if (hwrap < NFULL_H) begin
      hsat = NFULL_H;
    end
  end

  // zero span counts as one degree
  always_comb begin
    span_mag = span[GOAL_W-1] ? (GOAL_W + 1)'(-span) : (GOAL_W + 1)'(span);
    if (span == '0) begin
      span_mag = (GOAL_W + 1)'(1);
    end
  end

  assign hdiff    = GU_W'(heading) - gunits;
  assign pp       = DIVD_W'(errm) * $signed(DIVD_W'({1'b0, maxp}));
  assign num_mag  = num[DIVD_W-1] ? DIVD_W'(-num) : DIVD_W'(num);
  assign csum_mag = csum[SUM_W-1] ? SUM_W'(-csum) : SUM_W'(csum);

  assign div_dividend = cmd.fin_start ? DIVD_W'(csum_mag) : num_mag;
  assign div_divisor  = cmd.fin_start ? DIVS_W'(ccount) : den;

  ghpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.fin_start | cmd.div_start),
    .short_q  (cmd.fin_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign qsat = (quot > QW'(POWER_LIMIT)) ? PWRC_W'(POWER_LIMIT) : quot[PWRC_W-1:0];
  assign pwr  = qneg ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
  assign dq   = quot[DRIFT_QW-1:0];

  assign status.div_busy = div_busy;
  assign status.out_room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal      <= GOAL_W'(GOAL_RST);
      span      <= GOAL_W'(SPAN_RST);
      maxp      <= PWRC_W'(MAXP_RST);
      minp      <= PWRC_W'(MINP_RST);
      heading   <= '0;
      pending   <= '0;
      drift     <= '0;
      csum      <= '0;
      ccount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GOAL: goal <= $signed(cfg_data[GOAL_W-1:0]);
          REG_SPAN: span <= $signed(cfg_data[GOAL_W-1:0]);
          REG_MAXP: maxp <= cfg_data[PWRC_W-1:0];
          REG_MINP: minp <= cfg_data[PWRC_W-1:0];
        endcase
      end
      // a full count ignores further samples
      if (cmd.calib && ccount != '1) begin
        csum   <= csum + SUM_W'(rate_r);
        ccount <= ccount + 1'b1;
      end
      if (cmd.fin_end) begin
        if (ccount == '0) begin
          drift <= '0;
        end else begin
          drift <= qneg ? $signed(RATE_W'(-dq)) : $signed(RATE_W'(dq));
        end
        csum    <= '0;
        ccount  <= '0;
        heading <= '0;
        pending <= '0;
      end
      if (cmd.mul) begin
        pending <= pend_due ? '0 : pend_sum;
      end
      if (cmd.head && upd) begin
        heading <= HEAD_W'(hsat);
      end
      if (cmd.out_load || cmd.out_zero) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_r <= rate_sample;
      ms_r   <= elapsed_ms;
    end
    if (cmd.mul) begin
      prod <= delta * $signed({1'b0, pend_sum});
      upd  <= pend_due;
    end
    if (cmd.sum) begin
      hsum   <= HS_W'(heading) + HS_W'(prod);
      den    <= DIVS_W'(span_mag) * DIVS_W'(UNITS_PER_DEG);
      gunits <= GU_W'(goal) * UPD_G;
    end
    if (cmd.head) begin
      mind <= DIVD_W'(minp) * DIVD_W'(den);
    end
    if (cmd.err) begin
      errm  <= (hdiff < 0 ? -hdiff : hdiff) - OFFS_G;
      below <= (gunits - UNIT_G) > GU_W'(heading);
      above <= (gunits + UNIT_G) < GU_W'(heading);
    end
    if (cmd.num) begin
      num <= pp + $signed(mind);
    end
    if (cmd.fin_start) begin
      qneg <= csum[SUM_W-1];
    end else if (cmd.div_start) begin
      qneg <= num[DIVD_W-1];
    end
    if (cmd.out_zero) begin
      left_power  <= '0;
      right_power <= '0;
      turn_done   <= 1'b0;
      heading_now <= heading;
    end else if (cmd.out_load) begin
      heading_now <= heading;
      if (below) begin
        left_power  <= -pwr;
        right_power <= pwr;
        turn_done   <= 1'b0;
      end else if (above) begin
        left_power  <= pwr;
        right_power <= -pwr;
        turn_done   <= 1'b0;
      end else begin
        left_power  <= '0;
        right_power <= '0;
        turn_done   <= 1'b1;
      end
    end
  end

`include "gyro_heading_proportional_turn_assert.svh"

  `GHPT_ASSERT_IMP(a_heading_range, 1'b1, heading <= HEAD_W'(FULL_TURN) && heading >= -HEAD_W'(FULL_TURN))
  `GHPT_ASSERT_IMP(a_pending_below_min, 1'b1, pending < MIN_P)
  `GHPT_ASSERT_NXT(a_result_held, out_valid && out_stall, out_valid && $stable(heading_now))

endmodule
`default_nettype wire

>>> hw/rtl/ghpt_ctrl.sv
`default_nettype none
module ghpt_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ghpt_pkg::ACT_W-1:0]      action,
  input  wire ghpt_pkg::status_t               status,
  output ghpt_pkg::cmd_t                       cmd
);
  import ghpt_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CAL   = 4'd1;
  localparam logic [3:0] ST_FST   = 4'd2;
  localparam logic [3:0] ST_FWAIT = 4'd3;
  localparam logic [3:0] ST_FEND  = 4'd4;
  localparam logic [3:0] ST_ZOUT  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_HEAD  = 4'd8;
  localparam logic [3:0] ST_ERR   = 4'd9;
  localparam logic [3:0] ST_NUM   = 4'd10;
  localparam logic [3:0] ST_DST   = 4'd11;
  localparam logic [3:0] ST_DWAIT = 4'd12;
  localparam logic [3:0] ST_POUT  = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = state != ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (action)
            ACT_CONTROL: state_next = ST_MUL;
            ACT_CALIB:   state_next = ST_CAL;
            ACT_FINISH:  state_next = ST_FST;
            ACT_NONE:    state_next = ST_ZOUT;
          endcase
        end
      end
      ST_CAL: begin
        cmd.calib  = 1'b1;
        state_next = ST_ZOUT;
      end
      ST_FST: begin
        cmd.fin_start = 1'b1;
        state_next    = ST_FWAIT;
      end
      ST_FWAIT: begin
        if (!status.div_busy) begin
          state_next = ST_FEND;
        end
      end
      ST_FEND: begin
        cmd.fin_end = 1'b1;
        state_next  = ST_ZOUT;
      end
      ST_ZOUT: begin
        if (status.out_room) begin
          cmd.out_zero = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.head   = 1'b1;
        state_next = ST_ERR;
      end
      ST_ERR: begin
        cmd.err    = 1'b1;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        cmd.num    = 1'b1;
        state_next = ST_DST;
      end
      ST_DST: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!status.div_busy) begin
          state_next = ST_POUT;
        end
      end
      ST_POUT: begin
        if (status.out_room) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`include "gyro_heading_proportional_turn_assert.svh"

  `GHPT_ASSERT_NXT(a_control_starts, in_valid && !in_stall && action == ACT_CONTROL, state == ST_MUL)
  `GHPT_ASSERT_IMP(a_div_idle, state == ST_IDLE, !status.div_busy)
  `GHPT_ASSERT_NXT(a_result_done, state == ST_POUT && status.out_room, state == ST_IDLE)

endmodule
`default_nettype wire

>>> hw/rtl/gyro_heading_proportional_turn.sv
// control item: multiply, sum, heading, error, numerator, divider start and wait, output
// states, the shared divider forming the motor power; calibration sample: calib, then zero
// output; finish: start, wait (16-step drift divide), end, zero output; unused code: zero
// output only; one request in flight: next taken in the cycle after the result loads,
// later under out_stall; rst (synchronous, active high) clears heading, drift, calibration
// sums and loads the register defaults: goal 90, span 90, max power 95, min power 15
`default_nettype none
module gyro_heading_proportional_turn #(
  parameter int MIN_INTERVAL_MS = ghpt_pkg::MIN_INTERVAL_MS_DEF,
  parameter int COUNT_BITS      = ghpt_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ghpt_pkg::ACT_W-1:0]         action,
  input  wire logic signed [ghpt_pkg::RATE_W-1:0] rate_sample,
  input  wire logic [ghpt_pkg::MS_W-1:0]          elapsed_ms,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ghpt_pkg::PWR_W-1:0]       left_power,
  output logic signed [ghpt_pkg::PWR_W-1:0]       right_power,
  output logic                                    turn_done,
  output logic signed [ghpt_pkg::HEAD_W-1:0]      heading_now,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ghpt_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [ghpt_pkg::CFG_W-1:0]         cfg_data
);
  import ghpt_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ghpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  ghpt_dp #(
    .MIN_INTERVAL_MS (MIN_INTERVAL_MS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .rate_sample (rate_sample),
    .elapsed_ms  (elapsed_ms),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_power  (left_power),
    .right_power (right_power),
    .turn_done   (turn_done),
    .heading_now (heading_now)
  );

endmodule
`default_nettype wire

>>> sim/ghpt_turn_checker.sv
module ghpt_turn_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [ghpt_pkg::ACT_W-1:0]         action,
  input  logic signed [ghpt_pkg::RATE_W-1:0] rate_sample,
  input  logic [ghpt_pkg::MS_W-1:0]          elapsed_ms,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [ghpt_pkg::PWR_W-1:0]  left_power,
  input  logic signed [ghpt_pkg::PWR_W-1:0]  right_power,
  input  logic                               turn_done,
  input  logic signed [ghpt_pkg::HEAD_W-1:0] heading_now,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [ghpt_pkg::IDX_W-1:0]         cfg_index,
  input  logic [ghpt_pkg::CFG_W-1:0]         cfg_data,
  output int                                 mismatch_count,
  output int                                 outstanding
);
  import ghpt_pkg::*;

  localparam longint CALIB_FULL = (longint'(1) << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic signed [PWR_W-1:0]  left;
    logic signed [PWR_W-1:0]  right;
    logic                     done;
    logic signed [HEAD_W-1:0] head;
  } drive_t;

  drive_t drive_queue[$];
  drive_t want;
  drive_t got;
  int     bad_fields = 0;

  // predictor state, heading in 1/64000 degree
  longint heading_acc, pend_ms, drift_est, calib_total, calib_n;
  longint goal_deg, span_deg, max_pwr, min_pwr;

  function automatic drive_t predict_drive(input logic [ACT_W-1:0] act,
                                           input logic signed [RATE_W-1:0] rate,
                                           input logic [MS_W-1:0] ms);
    longint rate_v, goal_u, err, span, den, num, power, lp, rp;
    drive_t d;
    rate_v = longint'(rate);
    d = '0;
    case (act)
      ACT_CALIB: begin
        if (calib_n < CALIB_FULL) begin
          calib_total += rate_v;
          calib_n     += 1;
        end
      end
      ACT_FINISH: begin
        drift_est   = (calib_n != 0) ? calib_total / calib_n : 0;
        calib_total = 0;
        calib_n     = 0;
        heading_acc = 0;
        pend_ms     = 0;
      end
      ACT_CONTROL: begin
        pend_ms += longint'(ms);
        if (pend_ms >= MIN_INTERVAL_MS_DEF) begin
          heading_acc += (rate_v - drift_est) * pend_ms;
          pend_ms = 0;
          // one wrap, then clamp whatever is still out of range
          if (heading_acc > FULL_TURN) heading_acc -= FULL_TURN;
          else if (heading_acc < -FULL_TURN) heading_acc += FULL_TURN;
          if (heading_acc > FULL_TURN) heading_acc = FULL_TURN;
          else if (heading_acc < -FULL_TURN) heading_acc = -FULL_TURN;
        end
        goal_u = goal_deg * UNITS_PER_DEG;
        err = heading_acc - goal_u;
        if (err < 0) err = -err;
        span = (span_deg < 0) ? -span_deg : span_deg;
        if (span == 0) span = 1;
        den = span * UNITS_PER_DEG;
        num = (err - ERR_OFFSET_DEG * UNITS_PER_DEG) * max_pwr + min_pwr * den;
        power = num / den;
        if (power > POWER_LIMIT) power = POWER_LIMIT;
        else if (power < -POWER_LIMIT) power = -POWER_LIMIT;
        if (goal_u - DEADBAND_DEG * UNITS_PER_DEG > heading_acc) begin
          lp = -power;
          rp = power;
        end else if (goal_u + DEADBAND_DEG * UNITS_PER_DEG < heading_acc) begin
          lp = power;
          rp = -power;
        end else begin
          lp = 0;
          rp = 0;
          d.done = 1'b1;
        end
        d.left  = lp[PWR_W-1:0];
        d.right = rp[PWR_W-1:0];
      end
      default: ;
    endcase
    d.head = heading_acc[HEAD_W-1:0];
    return d;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      heading_acc = 0;
      pend_ms     = 0;
      drift_est   = 0;
      calib_total = 0;
      calib_n     = 0;
      goal_deg    = GOAL_RST;
      span_deg    = SPAN_RST;
      max_pwr     = MAXP_RST;
      min_pwr     = MINP_RST;
      drive_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GOAL: goal_deg = longint'($signed(cfg_data[GOAL_W-1:0]));
          REG_SPAN: span_deg = longint'($signed(cfg_data[GOAL_W-1:0]));
          REG_MAXP: max_pwr  = longint'(cfg_data[PWRC_W-1:0]);
          REG_MINP: min_pwr  = longint'(cfg_data[PWRC_W-1:0]);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          $error("result with no request waiting: left_power %0d right_power %0d",
                 left_power, right_power);
          bad_fields++;
        end else begin
          want = drive_queue.pop_front();
          got  = '{left_power, right_power, turn_done, heading_now};
          if (got.left !== want.left) begin
            $error("left_power expected %0d actual %0d", want.left, got.left);
            bad_fields++;
          end
          if (got.right !== want.right) begin
            $error("right_power expected %0d actual %0d", want.right, got.right);
            bad_fields++;
          end
          if (got.done !== want.done) begin
            $error("turn_done expected %0d actual %0d", want.done, got.done);
            bad_fields++;
          end
          if (got.head !== want.head) begin
            $error("heading_now expected %0d actual %0d", want.head, got.head);
            bad_fields++;
          end
        end
      end
      // results of this edge belong to older requests, so predict last
      if (in_valid && !in_stall)
        drive_queue.push_back(predict_drive(action, rate_sample, elapsed_ms));
    end
    outstanding    <= drive_queue.size();
    mismatch_count <= bad_fields;
  end

endmodule

>>> sim/testbench.sv
module testbench;
  import ghpt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 32;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [ACT_W-1:0]         action      = ACT_CONTROL;
  logic signed [RATE_W-1:0] rate_sample = '0;
  logic [MS_W-1:0]          elapsed_ms  = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic signed [PWR_W-1:0]  left_power;
  logic signed [PWR_W-1:0]  right_power;
  logic                     turn_done;
  logic signed [HEAD_W-1:0] heading_now;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index   = REG_GOAL;
  logic [CFG_W-1:0]         cfg_data    = '0;

  int   mismatch_count;
  int   outstanding;
  int   cycle_count = 0;
  int   stall_left  = 0;
  logic no_idle     = 1'b0;

  gyro_heading_proportional_turn uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .rate_sample(rate_sample), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_power(left_power), .right_power(right_power),
    .turn_done(turn_done), .heading_now(heading_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ghpt_turn_checker turn_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .rate_sample(rate_sample), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_power(left_power), .right_power(right_power),
    .turn_done(turn_done), .heading_now(heading_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // gain or offset, sometimes past 100, with junk in the unused upper bits
  function automatic int pick_power();
    int p;
    case ($urandom_range(0, 7))
      0: p = 0;
      1: p = 100;
      2: p = $urandom_range(101, 127);
      default: p = $urandom_range(0, 100);
    endcase
    return p + ($urandom_range(0, 7) << PWRC_W);
  endfunction

  always @(posedge clk) begin
    if (rst || no_idle) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_request(input logic [ACT_W-1:0] act, input int rate, input int ms);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    rate_sample <= rate[RATE_W-1:0];
    elapsed_ms  <= ms[MS_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // registers change only with no request in flight
  task automatic load_settings(input int goal, input int span, input int maxp,
                               input int minp);
    drain();
    put_reg(REG_GOAL, goal);
    put_reg(REG_SPAN, span);
    put_reg(REG_MAXP, maxp);
    put_reg(REG_MINP, minp);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase, cls, n, r, bias;
    int goal, span, maxp, minp;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings, time pending below the interval, then a wrap and clamp
    send_request(ACT_CONTROL, 0, 0);
    send_request(ACT_CONTROL, 100, 4);
    send_request(ACT_CONTROL, 100, 1);
    send_request(ACT_NONE, -1, 1023);
    send_request(ACT_CONTROL, 32767, 1023);
    send_request(ACT_CONTROL, 32767, 1023);
    send_request(ACT_CONTROL, 32767, 1023);
    send_request(ACT_CONTROL, -32768, 1023);
    // finish with no samples gives zero drift
    send_request(ACT_FINISH, 0, 0);

    // zero span, goal at zero: inside the deadband
    load_settings(0, 0, 100, 0);
    send_request(ACT_CONTROL, 0, 5);
    send_request(ACT_CONTROL, 10, 5);
    // negative average truncates toward zero
    send_request(ACT_CALIB, -7, 3);
    send_request(ACT_CALIB, -2, 3);
    send_request(ACT_FINISH, 0, 0);
    send_request(ACT_CONTROL, -4, 10);
    send_request(ACT_CONTROL, 200, 400);
    send_request(ACT_CONTROL, -32768, 1023);

    load_settings(-360, -360, 0, 100);
    send_request(ACT_CONTROL, -32768, 1023);
    send_request(ACT_CONTROL, -32768, 1023);
    send_request(ACT_CONTROL, 32767, 1023);

    load_settings(511, -512, 127, 0);
    send_request(ACT_CONTROL, 32767, 600);
    send_request(ACT_CONTROL, -1, 1);
    send_request(ACT_CONTROL, 1234, 7);

    // wide random samples back to back, then control steps
    load_settings(360, 1, 100, 100);
    no_idle <= 1'b1;
    send_request(ACT_FINISH, 0, 0);
    repeat (6) send_request(ACT_CALIB, $urandom, $urandom_range(0, 1023));
    send_request(ACT_FINISH, $urandom, 0);
    repeat (4) send_request(ACT_CONTROL, $urandom, $urandom_range(0, 1023));
    no_idle <= 1'b0;

    for (phase = 0; phase < 9; phase++) begin
      cls = $urandom_range(0, 2);
      case ($urandom_range(0, 7))
        0: goal = -360;
        1: goal = 360;
        2: goal = $urandom_range(0, 1023) - 512;
        default: goal = $urandom_range(0, 720) - 360;
      endcase
      // slow rates near a zero goal reach the deadband
      if (cls == 0 && $urandom_range(0, 1) == 1) goal = 0;
      case ($urandom_range(0, 9))
        0: span = 0;
        1: span = -360;
        2: span = 360;
        3: span = ($urandom_range(0, 1) == 1) ? 1 : -1;
        4: span = $urandom_range(0, 1023) - 512;
        default: span = $urandom_range(0, 720) - 360;
      endcase
      maxp = pick_power();
      minp = pick_power();
      load_settings(goal, span, maxp, minp);
      no_idle <= (phase % 4 == 2);

      if ($urandom_range(0, 2) != 0) begin
        bias = $urandom_range(0, 400) - 200;
        n = $urandom_range(0, 24);
        repeat (n)
          send_request(ACT_CALIB, bias + $urandom_range(0, 40) - 20, $urandom_range(0, 1023));
        send_request(ACT_FINISH, $urandom, $urandom_range(0, 1023));
      end

      n = $urandom_range(25, 55);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          send_request(ACT_NONE, $urandom, $urandom_range(0, 1023));
        else if (r < 6)
          send_request(ACT_CALIB, $urandom, $urandom_range(0, 1023));
        else if (r < 7)
          send_request(ACT_FINISH, $urandom, $urandom_range(0, 1023));
        else begin
          case (cls)
            0: send_request(ACT_CONTROL, $urandom_range(0, 60) - 30, $urandom_range(0, 8));
            1: send_request(ACT_CONTROL, $urandom_range(0, 4000) - 2000,
                            $urandom_range(0, 20));
            default: send_request(ACT_CONTROL, $urandom, $urandom_range(0, 1023));
          endcase
        end
      end
    end

    drain();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ghpt_pkg.sv
hw/rtl/ghpt_div.sv
hw/rtl/ghpt_dp.sv
hw/rtl/ghpt_ctrl.sv
hw/rtl/gyro_heading_proportional_turn.sv
sim/ghpt_turn_checker.sv
sim/testbench.sv
